FILE: sv/rotating_square_string_hash_unit_assert.svh
`ifndef ROTATING_SQUARE_STRING_HASH_UNIT_ASSERT_SVH
`define ROTATING_SQUARE_STRING_HASH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define RSSH_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

`define RSSH_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define RSSH_ASSERT(lbl, clk, rst_n, prop)

`define RSSH_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/rssh_pkg.sv
package rssh_pkg;

  localparam int unsigned AccW      = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned RotW      = 4;
  localparam int unsigned FoldShift = 16;

  localparam logic [AccW-1:0] PosStart = 32'h0000_0100;
  localparam logic [AccW-1:0] PosStep  = 32'h0000_0100;

  localparam int unsigned DefQueueDepth = 2;
  localparam int unsigned DefOutDepth   = 2;

  typedef struct packed {
    logic [AccW-1:0] square;
    logic [RotW-1:0] rot;
    logic            last;
  } item_t;

  function automatic logic [AccW-1:0] rotl(input logic [AccW-1:0] x,
                                           input logic [RotW-1:0] r);
    logic [2*AccW-1:0] d;
    d = {x, x} << r;
    return d[2*AccW-1:AccW];
  endfunction

endpackage

FILE: sv/rssh_fifo.sv
module rssh_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] din_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] dout_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

FILE: sv/rssh_front.sv
module rssh_front import rssh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [CharW-1:0] char_byte_i,
  input  logic             last_char_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output item_t            item_o
);

  logic [AccW-1:0] pos_q, pos_d;
  logic            valid_q, valid_d;
  item_t           item_q, item_d;
  logic [AccW-1:0] v;
  logic            accept;

  assign in_ready_o   = !valid_q || item_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;
  assign v            = pos_q | {{(AccW-CharW){1'b0}}, char_byte_i};

  always_comb begin
    pos_d       = pos_q;
    valid_d     = valid_q;
    item_d      = item_q;
    if (accept) begin
      valid_d       = 1'b1;
      item_d.square = v * v;
      item_d.rot    = v[RotW+1:2] ^ v[RotW-1:0];
      item_d.last   = last_char_i;
      pos_d         = last_char_i ? PosStart : pos_q + PosStep;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosStart;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

FILE: sv/rssh_back.sv
module rssh_back import rssh_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  item_t           item_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [AccW-1:0] hash_o
);

  logic [AccW-1:0] acc_q, acc_d, acc_n;
  logic            take;

  assign item_ready_o = !item_i.last || res_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign acc_n        = rotl(acc_q, item_i.rot) ^ item_i.square;
  assign res_valid_o  = take && item_i.last;
  assign hash_o       = acc_n ^ (acc_n >> FoldShift);

  always_comb begin
    acc_d = acc_q;
    if (take) begin
      acc_d = item_i.last ? '0 : acc_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

FILE: sv/rotating_square_string_hash_unit.sv
// Rotating-square string hash: feed one key character per transaction with last_char_i
// set on the final one; one folded 32-bit hash per string appears on the result queue.
// A character is accepted every cycle while the queues have room. It is registered
// in the front register (position OR, 32x32 square, rotate amount), then passes a
// small queue into the accumulator, which rotates and XORs once per cycle unless a
// last character waits on a full result queue; each hash is pushed to the result queue.
// The accumulator loop sets the rate at one character a cycle.
`include "rotating_square_string_hash_unit_assert.svh"

module rotating_square_string_hash_unit import rssh_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth,
  parameter int unsigned OutDepth   = DefOutDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [CharW-1:0] char_byte_i,
  input  logic             last_char_i,
  output logic             empty,
  input  logic             pop,
  output logic [AccW-1:0]  hash_value_o
);

  logic            in_ready;
  logic            front_valid, mid_full, mid_empty, mid_pop;
  item_t           front_item, mid_item;
  logic            back_ready, res_valid, out_full;
  logic [AccW-1:0] res_hash;

  assign full    = !in_ready;
  assign mid_pop = !mid_empty && back_ready;

  rssh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (push),
    .in_ready_o   (in_ready),
    .char_byte_i  (char_byte_i),
    .last_char_i  (last_char_i),
    .item_valid_o (front_valid),
    .item_ready_i (!mid_full),
    .item_o       (front_item)
  );

  rssh_fifo #(
    .Width ($bits(item_t)),
    .Depth (QueueDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .full_o  (mid_full),
    .din_i   (front_item),
    .pop_i   (back_ready),
    .empty_o (mid_empty),
    .dout_o  (mid_item)
  );

  rssh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!mid_empty),
    .item_ready_o (back_ready),
    .item_i       (mid_item),
    .res_valid_o  (res_valid),
    .res_ready_i  (!out_full),
    .hash_o       (res_hash)
  );

  rssh_fifo #(
    .Width (AccW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .full_o  (out_full),
    .din_i   (res_hash),
    .pop_i   (pop),
    .empty_o (empty),
    .dout_o  (hash_value_o)
  );

  `RSSH_ASSERT_NEVER(a_res_into_full, clk_i, rst_ni, res_valid && out_full)
  `RSSH_ASSERT(a_res_only_on_last, clk_i, rst_ni, res_valid |-> (mid_pop && mid_item.last))
  `RSSH_ASSERT(a_last_makes_res, clk_i, rst_ni, (mid_pop && mid_item.last) |-> res_valid)
  `RSSH_ASSERT(a_res_shows, clk_i, rst_ni, res_valid |=> !empty)

endmodule
